>>> rtl/atf_pkg.sv
// Package for the ASCII telegram framer: queue entry type, ASCII constants,
// and decimal digit helpers. No dependencies.
`default_nettype none

package atf_pkg;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_DATA  = 2'd2
    } kind_t;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;

    localparam logic [6:0] CH_ZERO = 7'h30;
    localparam logic [6:0] CH_ONE  = 7'h31;
    localparam logic [6:0] CH_TWO  = 7'h32;
    localparam logic [6:0] CH_EQ   = 7'h3D;
    localparam logic [6:0] CH_QM   = 7'h3F;
    localparam logic [6:0] CH_NL   = 7'h0A;

    localparam logic [9:0] MAX_NUM = 10'd999;
    localparam logic [6:0] MAX_LEN = 7'd99;

    typedef struct packed {
        kind_t       kind;
        logic        last;
        logic [11:0] addr_bcd;
        logic [11:0] par_bcd;
        logic [7:0]  len_bcd;
        logic [6:0]  data;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } q_wr_t;

    typedef struct packed {
        logic   avail;
        entry_t entry;
    } q_rd_t;

    // v < 1000: hundreds by *41>>12, tens by *103>>10
    function automatic logic [11:0] dec3(input logic [9:0] v);
        logic [15:0] ph;
        logic [3:0]  h;
        logic [6:0]  r;
        logic [13:0] pt;
        logic [3:0]  t;
        logic [3:0]  o;
        ph = 16'(v) * 16'd41;
        h  = ph[15:12];
        r  = 7'(v - 10'(h) * 10'd100);
        pt = 14'(r) * 14'd103;
        t  = pt[13:10];
        o  = 4'(r - 7'(t) * 7'd10);
        return {h, t, o};
    endfunction

    function automatic logic [6:0] ascii_digit(input logic [3:0] d);
        return {3'b011, d};
    endfunction

endpackage

`default_nettype wire

>>> rtl/ascii_telegram_framer.sv
// Top level of the ASCII telegram framer: front end, two-entry queue and
// byte sequencer. Uses atf_pkg, atf_front, atf_queue, atf_back.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------------
//   item     | item_valid / item_stall    | operation, device_address,
//            |                            | parameter_number, data_length, data_byte
//   result   | result_valid / result_stall| out_byte, frame_end, run_last
//
// One result byte leaves per cycle while result_stall is low; the sequencer is
// the limit. Read headers, zero-length write headers and last data bytes end
// in the checksum and newline. Items with no result push no queue entry.
// The two-entry queue lets the next item in while a header drains; item_stall
// rises only when it is full. Reset clears frame state and the queue at once.
`default_nettype none

module ascii_telegram_framer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [9:0]  device_address,
    input  wire logic [9:0]  parameter_number,
    input  wire logic [6:0]  data_length,
    input  wire logic [6:0]  data_byte,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [6:0]       out_byte,
    output logic             frame_end,
    output logic             run_last
);
    import atf_pkg::*;

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  pop;

    atf_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .operation        (operation),
        .device_address   (device_address),
        .parameter_number (parameter_number),
        .data_length      (data_length),
        .data_byte        (data_byte),
        .q_full           (q_full),
        .q_wr             (q_wr)
    );

    atf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (pop),
        .full  (q_full),
        .q_rd  (q_rd)
    );

    atf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_rd         (q_rd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .frame_end    (frame_end),
        .run_last     (run_last)
    );

endmodule

`default_nettype wire

>>> rtl/atf_front.sv
// Front end: accepts input items, tracks the open write frame, converts
// numbers to decimal digits and pushes work entries. Uses atf_pkg.
`default_nettype none

module atf_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire logic [1:0]    operation,
    input  wire logic [9:0]    device_address,
    input  wire logic [9:0]    parameter_number,
    input  wire logic [6:0]    data_length,
    input  wire logic [6:0]    data_byte,
    input  wire logic          q_full,
    output atf_pkg::q_wr_t     q_wr
);
    import atf_pkg::*;

    logic       open_reg;
    logic       open_next;
    logic [6:0] remain_reg;
    logic [6:0] remain_next;
    logic       accept;
    logic [9:0] addr_sat;
    logic [9:0] par_sat;
    logic [6:0] len_sat;
    logic [11:0] len_dig;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    always_comb
    begin
        addr_sat = (device_address > MAX_NUM) ? MAX_NUM : device_address;
        par_sat  = (parameter_number > MAX_NUM) ? MAX_NUM : parameter_number;
        len_sat  = (data_length > MAX_LEN) ? MAX_LEN : data_length;
        len_dig  = dec3({3'b000, len_sat});

        open_next              = open_reg;
        remain_next            = remain_reg;
        q_wr.push              = 1'b0;
        q_wr.entry.kind        = KIND_DATA;
        q_wr.entry.last        = 1'b0;
        q_wr.entry.addr_bcd    = dec3(addr_sat);
        q_wr.entry.par_bcd     = dec3(par_sat);
        q_wr.entry.len_bcd     = len_dig[7:0];
        q_wr.entry.data        = data_byte;

        if (accept)
        begin
            case (operation)
                OP_READ:
                begin
                    q_wr.push       = 1'b1;
                    q_wr.entry.kind = KIND_READ;
                    q_wr.entry.last = 1'b1;
                    open_next       = 1'b0;
                    remain_next     = 7'd0;
                end
                OP_WRITE:
                begin
                    q_wr.push       = 1'b1;
                    q_wr.entry.kind = KIND_WRITE;
                    q_wr.entry.last = (len_sat == 7'd0);
                    open_next       = (len_sat != 7'd0);
                    remain_next     = len_sat;
                end
                OP_DATA:
                begin
                    if (open_reg)
                    begin
                        q_wr.push       = 1'b1;
                        q_wr.entry.kind = KIND_DATA;
                        q_wr.entry.last = (remain_reg == 7'd1);
                        remain_next     = remain_reg - 7'd1;
                        open_next       = (remain_reg != 7'd1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            remain_reg <= 7'd0;
        end
        else
        begin
            open_reg   <= open_next;
            remain_reg <= remain_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/atf_queue.sv
// Two-entry queue between the front end and the byte sequencer.
// Uses atf_pkg for the entry type.
`default_nettype none

module atf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire atf_pkg::q_wr_t q_wr,
    input  wire logic          pop,
    output logic               full,
    output atf_pkg::q_rd_t     q_rd
);
    import atf_pkg::*;

    entry_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full        = (count_reg == 2'd2);
    assign q_rd.avail  = (count_reg != 2'd0);
    assign q_rd.entry  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (q_wr.push && !pop)
            count_next = count_reg + 2'd1;
        else if (!q_wr.push && pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
            mem_reg[wr_ptr_reg] <= q_wr.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (q_wr.push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/atf_back.sv
// Byte sequencer: walks each queued entry byte by byte, keeps the running
// checksum and drives the registered result port. Uses atf_pkg.
`default_nettype none

module atf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire atf_pkg::q_rd_t q_rd,
    output logic               pop,
    output logic               result_valid,
    input  wire logic          result_stall,
    output logic [6:0]         out_byte,
    output logic               frame_end,
    output logic               run_last
);
    import atf_pkg::*;

    logic [3:0]  step_reg;
    logic [3:0]  step_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [7:0]  cks_reg;
    logic        res_valid_reg;
    logic [6:0]  res_byte_reg;
    logic        res_end_reg;
    logic        res_last_reg;

    logic        advance;
    logic [3:0]  tail_start;
    logic        has_tail;
    logic [3:0]  end_step;
    logic        in_tail;
    logic [1:0]  tidx;
    logic [11:0] sum_dig;
    logic [6:0]  byte_c;
    logic        end_c;
    logic        last_c;
    entry_t      e;

    assign e            = q_rd.entry;
    assign advance      = q_rd.avail && (!res_valid_reg || !result_stall);
    assign result_valid = res_valid_reg;
    assign out_byte     = res_byte_reg;
    assign frame_end    = res_end_reg;
    assign run_last     = res_last_reg;

    always_comb
    begin
        case (e.kind)
            KIND_READ:  tail_start = 4'd12;
            KIND_WRITE: tail_start = 4'd10;
            default:    tail_start = 4'd1;
        endcase
        has_tail = (e.kind == KIND_READ) || e.last;
        end_step = has_tail ? (tail_start + 4'd3) : (tail_start - 4'd1);
        in_tail  = (step_reg >= tail_start);
        tidx     = 2'(step_reg - tail_start);
        sum_dig  = dec3({2'b00, sum_reg});
        last_c   = (step_reg == end_step);
        end_c    = 1'b0;
        byte_c   = CH_ZERO;

        if (in_tail)
        begin
            case (tidx)
                2'd0: byte_c = ascii_digit(sum_dig[11:8]);
                2'd1: byte_c = ascii_digit(cks_reg[7:4]);
                2'd2: byte_c = ascii_digit(cks_reg[3:0]);
                default:
                begin
                    byte_c = CH_NL;
                    end_c  = 1'b1;
                end
            endcase
        end
        else if (e.kind == KIND_DATA)
        begin
            byte_c = e.data;
        end
        else
        begin
            case (step_reg)
                4'd0:  byte_c = ascii_digit(e.addr_bcd[11:8]);
                4'd1:  byte_c = ascii_digit(e.addr_bcd[7:4]);
                4'd2:  byte_c = ascii_digit(e.addr_bcd[3:0]);
                4'd3:  byte_c = (e.kind == KIND_READ) ? CH_ZERO : CH_ONE;
                4'd4:  byte_c = CH_ZERO;
                4'd5:  byte_c = ascii_digit(e.par_bcd[11:8]);
                4'd6:  byte_c = ascii_digit(e.par_bcd[7:4]);
                4'd7:  byte_c = ascii_digit(e.par_bcd[3:0]);
                4'd8:  byte_c = (e.kind == KIND_READ) ? CH_ZERO
                                                      : ascii_digit(e.len_bcd[7:4]);
                4'd9:  byte_c = (e.kind == KIND_READ) ? CH_TWO
                                                      : ascii_digit(e.len_bcd[3:0]);
                4'd10: byte_c = CH_EQ;
                4'd11: byte_c = CH_QM;
                default: byte_c = CH_ZERO;
            endcase
        end

        pop       = advance && last_c;
        step_next = last_c ? 4'd0 : (step_reg + 4'd1);
        if (end_c)
            sum_next = 8'd0;
        else if ((e.kind != KIND_DATA) && (step_reg == 4'd0))
            sum_next = {1'b0, byte_c};
        else
            sum_next = sum_reg + {1'b0, byte_c};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 4'd0;
            sum_reg       <= 8'd0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            step_reg      <= step_next;
            sum_reg       <= sum_next;
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_byte_reg <= byte_c;
            res_end_reg  <= end_c;
            res_last_reg <= last_c;
            if (in_tail && (tidx == 2'd0))
                cks_reg <= sum_dig[7:0];
        end
    end

endmodule

`default_nettype wire
